>>> hdl/sitrt_pkg.sv
// ----------------------------------------------------------------------------
// sitrt_pkg
// Shared types and codes for the signed integer to radix text converter.
// ----------------------------------------------------------------------------
`default_nettype none

package sitrt_pkg;

   typedef logic [7:0] char_type;
   typedef logic [1:0] func_type;

   localparam func_type FUNC_CLEAR   = 2'd0;
   localparam func_type FUNC_APPEND  = 2'd1;
   localparam func_type FUNC_CONVERT = 2'd2;

   localparam char_type PLUS_CHAR  = 8'h2B;
   localparam char_type MINUS_CHAR = 8'h2D;
   localparam char_type NULL_CHAR  = 8'h00;

   localparam int CHAR_SPACE = 256;

endpackage

`default_nettype wire

>>> hdl/signed_integer_to_radix_text.sv
// ----------------------------------------------------------------------------
// signed_integer_to_radix_text
// Clear and append requests are handled in the idle state. A convert runs
// the bit-serial divider, one quotient bit per cycle, for each digit, then
// reads each digit through the two memory read ports, digit buffer then
// alphabet, and emits its character; emission waits on rsp_stall.
// Reset empties the alphabet and clears its invalid flag and seen-character
// map; the alphabet and digit memories keep their contents.
// ----------------------------------------------------------------------------
`default_nettype none

module signed_integer_to_radix_text #(
   parameter int ALPHABET_DEPTH = 256,
   parameter int NUMBER_WIDTH   = 32
) (
   input  wire logic                           clock,
   input  wire logic                           reset,
   input  wire logic                           req_valid,
   output logic                                req_stall,
   input  wire logic [1:0]                     req_func,
   input  wire logic [7:0]                     req_alphabet_char,
   input  wire logic signed [NUMBER_WIDTH-1:0] req_value,
   output logic                                rsp_valid,
   input  wire logic                           rsp_stall,
   output logic [7:0]                          rsp_out_char,
   output logic                                rsp_last
);

   localparam int CAPACITY = (ALPHABET_DEPTH < 255) ? ALPHABET_DEPTH : 255;
   localparam int LEN_W    = $clog2(CAPACITY + 1);
   localparam int AW       = $clog2(ALPHABET_DEPTH);
   localparam int DW       = $clog2(NUMBER_WIDTH);
   localparam int CW       = $clog2(NUMBER_WIDTH + 1);

   localparam logic [LEN_W-1:0] CAP_LEN    = LEN_W'(CAPACITY);
   localparam logic [LEN_W-1:0] MIN_LEN    = LEN_W'(2);
   localparam logic [DW-1:0]    LAST_BIT   = DW'(NUMBER_WIDTH - 1);
   localparam logic [CW-1:0]    DIGITS_MAX = CW'(NUMBER_WIDTH);

   localparam logic [2:0] S_IDLE     = 3'd0;
   localparam logic [2:0] S_SIGN     = 3'd1;
   localparam logic [2:0] S_DIV      = 3'd2;
   localparam logic [2:0] S_RD_DIGIT = 3'd3;
   localparam logic [2:0] S_RD_CHAR  = 3'd4;
   localparam logic [2:0] S_EMIT     = 3'd5;

   logic [2:0]                         state_ff, state_in;
   logic [LEN_W-1:0]                   len_ff, len_in;
   logic                               invalid_ff, invalid_in;
   logic [sitrt_pkg::CHAR_SPACE-1:0]   seen_ff, seen_in;
   logic [NUMBER_WIDTH-1:0]            mag_ff, mag_in;
   logic [LEN_W-1:0]                   rem_ff, rem_in;
   logic                               qnz_ff, qnz_in;
   logic [DW-1:0]                      bit_ff, bit_in;
   logic [CW-1:0]                      dcount_ff, dcount_in;
   logic                               rsp_valid_ff, rsp_valid_in;
   sitrt_pkg::char_type                rsp_char_ff, rsp_char_in;
   logic                               rsp_last_ff, rsp_last_in;

   sitrt_pkg::char_type                alphabet_ff [ALPHABET_DEPTH];
   logic [AW-1:0]                      digit_buffer_ff [NUMBER_WIDTH];
   sitrt_pkg::char_type                alpha_rd_ff;
   logic [AW-1:0]                      digit_rd_ff;

   logic                               alpha_we, alpha_re;
   logic                               digit_we, digit_re;
   logic [DW-1:0]                      digit_waddr, digit_raddr;
   logic [AW-1:0]                      digit_wdata;

   logic                               req_accept, slot_free, append_bad;
   logic [NUMBER_WIDTH-1:0]            neg_value;
   logic [LEN_W:0]                     rem_shift, base_ext, rem_sub;
   logic                               div_ge, quot_nonzero;
   logic [LEN_W-1:0]                   rem_next;
   logic [CW-1:0]                      dcount_inc, dcount_dec;

   assign req_stall    = (state_ff != S_IDLE);
   assign req_accept   = req_valid && !req_stall;
   assign slot_free    = !rsp_valid_ff || !rsp_stall;
   assign rsp_valid    = rsp_valid_ff;
   assign rsp_out_char = rsp_char_ff;
   assign rsp_last     = rsp_last_ff;

   assign append_bad = (req_alphabet_char == sitrt_pkg::PLUS_CHAR)
                    || (req_alphabet_char == sitrt_pkg::MINUS_CHAR)
                    || seen_ff[req_alphabet_char];
   assign neg_value  = '0 - req_value;

   // One restoring division step: shift in the next magnitude bit.
   assign rem_shift    = {rem_ff, mag_ff[NUMBER_WIDTH-1]};
   assign base_ext     = {1'b0, len_ff};
   assign div_ge       = (rem_shift >= base_ext);
   assign rem_sub      = rem_shift - base_ext;
   assign rem_next     = div_ge ? rem_sub[LEN_W-1:0] : rem_shift[LEN_W-1:0];
   assign quot_nonzero = qnz_ff || div_ge;
   assign dcount_inc   = dcount_ff + 1'b1;
   assign dcount_dec   = dcount_ff - 1'b1;

   always_comb begin
      state_in     = state_ff;
      len_in       = len_ff;
      invalid_in   = invalid_ff;
      seen_in      = seen_ff;
      mag_in       = mag_ff;
      rem_in       = rem_ff;
      qnz_in       = qnz_ff;
      bit_in       = bit_ff;
      dcount_in    = dcount_ff;
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      rsp_char_in  = rsp_char_ff;
      rsp_last_in  = rsp_last_ff;
      alpha_we     = 1'b0;
      alpha_re     = 1'b0;
      digit_we     = 1'b0;
      digit_re     = 1'b0;
      digit_waddr  = dcount_ff[DW-1:0];
      digit_wdata  = rem_next[AW-1:0];
      digit_raddr  = dcount_dec[DW-1:0];

      unique case (state_ff)
         S_IDLE: begin
            if (req_accept) begin
               unique case (req_func)
                  sitrt_pkg::FUNC_CLEAR: begin
                     len_in     = '0;
                     invalid_in = 1'b0;
                     seen_in    = '0;
                  end
                  sitrt_pkg::FUNC_APPEND: begin
                     if (req_alphabet_char != sitrt_pkg::NULL_CHAR) begin
                        if (len_ff >= CAP_LEN) begin
                           invalid_in = 1'b1;
                        end else begin
                           invalid_in                 = invalid_ff || append_bad;
                           seen_in[req_alphabet_char] = 1'b1;
                           alpha_we                   = 1'b1;
                           len_in                     = len_ff + 1'b1;
                        end
                     end
                  end
                  sitrt_pkg::FUNC_CONVERT: begin
                     if (!invalid_ff && (len_ff >= MIN_LEN)) begin
                        mag_in    = req_value[NUMBER_WIDTH-1] ? neg_value : req_value;
                        rem_in    = '0;
                        qnz_in    = 1'b0;
                        bit_in    = '0;
                        dcount_in = '0;
                        state_in  = req_value[NUMBER_WIDTH-1] ? S_SIGN : S_DIV;
                     end
                  end
                  default: begin
                  end
               endcase
            end
         end
         S_SIGN: begin
            if (slot_free) begin
               rsp_valid_in = 1'b1;
               rsp_char_in  = sitrt_pkg::MINUS_CHAR;
               rsp_last_in  = 1'b0;
               state_in     = S_DIV;
            end
         end
         S_DIV: begin
            mag_in = {mag_ff[NUMBER_WIDTH-2:0], div_ge};
            rem_in = rem_next;
            qnz_in = quot_nonzero;
            bit_in = bit_ff + 1'b1;
            if (bit_ff == LAST_BIT) begin
               digit_we  = 1'b1;
               dcount_in = dcount_inc;
               bit_in    = '0;
               rem_in    = '0;
               qnz_in    = 1'b0;
               if (!quot_nonzero || (dcount_inc == DIGITS_MAX)) begin
                  state_in = S_RD_DIGIT;
               end
            end
         end
         S_RD_DIGIT: begin
            digit_re  = 1'b1;
            dcount_in = dcount_dec;
            state_in  = S_RD_CHAR;
         end
         S_RD_CHAR: begin
            alpha_re = 1'b1;
            state_in = S_EMIT;
         end
         S_EMIT: begin
            if (slot_free) begin
               rsp_valid_in = 1'b1;
               rsp_char_in  = alpha_rd_ff;
               rsp_last_in  = (dcount_ff == '0);
               state_in     = (dcount_ff == '0) ? S_IDLE : S_RD_DIGIT;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         len_ff       <= '0;
         invalid_ff   <= 1'b0;
         seen_ff      <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         len_ff       <= len_in;
         invalid_ff   <= invalid_in;
         seen_ff      <= seen_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      mag_ff      <= mag_in;
      rem_ff      <= rem_in;
      qnz_ff      <= qnz_in;
      bit_ff      <= bit_in;
      dcount_ff   <= dcount_in;
      rsp_char_ff <= rsp_char_in;
      rsp_last_ff <= rsp_last_in;
   end

   always_ff @(posedge clock) begin
      if (alpha_we) begin
         alphabet_ff[len_ff[AW-1:0]] <= req_alphabet_char;
      end
      if (alpha_re) begin
         alpha_rd_ff <= alphabet_ff[digit_rd_ff];
      end
   end

   always_ff @(posedge clock) begin
      if (digit_we) begin
         digit_buffer_ff[digit_waddr] <= digit_wdata;
      end
      if (digit_re) begin
         digit_rd_ff <= digit_buffer_ff[digit_raddr];
      end
   end

endmodule

`default_nettype wire

>>> hdl/sitrt_checker.sv
// ----------------------------------------------------------------------------
// sitrt_checker
// Port-level checks for the radix text converter, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

module sitrt_checker (
   input wire logic       clock,
   input wire logic       reset,
   input wire logic       req_valid,
   input wire logic       req_stall,
   input wire logic [1:0] req_func,
   input wire logic       rsp_valid,
   input wire logic       rsp_stall,
   input wire logic [7:0] rsp_out_char,
   input wire logic       rsp_last
);

   // A stalled response holds its character and flag.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_out_char) && $stable(rsp_last))
      else $error("stalled response changed");

   // Clear and append requests produce no new response.
   assert property (@(posedge clock) disable iff (reset)
      req_valid && !req_stall && (req_func != sitrt_pkg::FUNC_CONVERT)
      |=> !rsp_valid || $past(rsp_valid && rsp_stall))
      else $error("response appeared after a non-convert request");

   // While a conversion is still emitting, no new request is taken.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_last |-> req_stall)
      else $error("request accepted in the middle of a conversion");

   // A usable alphabet never holds the minus sign, so it cannot end a text.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_last |-> rsp_out_char != sitrt_pkg::MINUS_CHAR)
      else $error("conversion ended on the sign character");

endmodule

bind signed_integer_to_radix_text sitrt_checker u_sitrt_checker (
   .clock        (clock),
   .reset        (reset),
   .req_valid    (req_valid),
   .req_stall    (req_stall),
   .req_func     (req_func),
   .rsp_valid    (rsp_valid),
   .rsp_stall    (rsp_stall),
   .rsp_out_char (rsp_out_char),
   .rsp_last     (rsp_last)
);

`default_nettype wire
